/* sv/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int PoolUnitsDef = 128;  // default pool size in units
  localparam int AmountW      = 8;    // width of the amount field and lengths
  localparam int StartW       = 7;    // width of the start_address field

  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_REL_READ,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              status;
    logic [StartW-1:0] start_address;
  } ffba_res_t;

endpackage

/* sv/ffba_ram.sv */
// ----------------------------------------------------------------------------
// ffba_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: clearing pass, first-fit scan over the used map, marking and
// freeing passes, length bookkeeping and result formation.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; #(
  parameter int POOL_UNITS = PoolUnitsDef,
  parameter int AW         = $clog2(POOL_UNITS)
) (
  input  logic               clk,
  input  logic               rst,
  // input item
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [AmountW-1:0] amount,
  // result handoff
  output logic               res_valid,
  input  logic               res_ready,
  output ffba_res_t          res,
  // used map
  output logic               used_we,
  output logic [AW-1:0]      used_waddr,
  output logic               used_wdata,
  output logic [AW-1:0]      used_raddr,
  input  logic               used_rdata,
  // block lengths
  output logic               blen_we,
  output logic [AW-1:0]      blen_waddr,
  output logic [AmountW-1:0] blen_wdata,
  output logic [AW-1:0]      blen_raddr,
  input  logic [AmountW-1:0] blen_rdata
);

  localparam logic [AW-1:0] LastIdx = AW'(POOL_UNITS - 1);

  state_t             state, state_next;
  logic [AW-1:0]      clr_idx;
  logic [AW-1:0]      chk_idx;
  logic [AW-1:0]      run_start;
  logic [AmountW-1:0] run;
  logic               op_func;
  logic [AmountW-1:0] op_amount;
  logic [AW-1:0]      wr_idx;
  logic [AmountW-1:0] left;

  logic               accept;
  logic               req_bad, rel_bad;
  logic [AW-1:0]      start_now;
  logic [AmountW-1:0] run_inc;
  logic               scan_hit, scan_end, wr_last;
  logic [AmountW-1:0] start_ext;

  assign accept    = in_valid && !in_stall;
  assign req_bad   = (amount == '0) || ({1'b0, amount} > (AmountW+1)'(POOL_UNITS));
  assign rel_bad   = {1'b0, amount} >= (AmountW+1)'(POOL_UNITS);
  assign start_now = (run == '0) ? chk_idx : run_start;
  assign run_inc   = run + AmountW'(1);
  assign scan_hit  = !used_rdata && (run_inc == op_amount);
  assign scan_end  = chk_idx == LastIdx;
  assign wr_last   = (left == AmountW'(1)) || (wr_idx == LastIdx);
  assign start_ext = AmountW'(start_now);

  // read address for the next unit; its data returns in the next cycle, when chk_idx has advanced to it
  assign used_raddr = (state == ST_SCAN) ? AW'(chk_idx + 1'b1) : '0;
  assign blen_raddr = amount[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    res_valid  = 1'b0;
    used_we    = 1'b0;
    used_waddr = wr_idx;
    used_wdata = (op_func == FUNC_REQUEST);
    blen_we    = 1'b0;
    blen_waddr = op_amount[AW-1:0];
    blen_wdata = '0;
    case (state)
      ST_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr_idx;
        used_wdata = 1'b0;
        blen_we    = 1'b1;
        blen_waddr = clr_idx;
        if (clr_idx == LastIdx) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          if (func == FUNC_REQUEST) begin
            state_next = req_bad ? ST_DONE : ST_SCAN;
          end else begin
            state_next = rel_bad ? ST_DONE : ST_REL_READ;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          blen_we    = 1'b1;
          blen_waddr = start_now;
          blen_wdata = op_amount;
          state_next = ST_WRITE;
        end else if (scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_REL_READ: begin
        if (blen_rdata == '0) begin
          state_next = ST_DONE;
        end else begin
          blen_we    = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        used_we = 1'b1;
        if (wr_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= AW'(clr_idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_func   <= func;
          op_amount <= amount;
          chk_idx   <= '0;
          run       <= '0;
          res       <= '{status: STATUS_ERR, start_address: '0};
        end
      end
      ST_SCAN: begin
        chk_idx <= AW'(chk_idx + 1'b1);
        if (used_rdata) begin
          run <= '0;
        end else begin
          run_start <= start_now;
          run       <= run_inc;
        end
        if (scan_hit) begin
          wr_idx <= start_now;
          left   <= op_amount;
          res    <= '{status: STATUS_OK, start_address: start_ext[StartW-1:0]};
        end
      end
      ST_REL_READ: begin
        wr_idx <= op_amount[AW-1:0];
        left   <= blen_rdata;
        if (blen_rdata != '0) begin
          res <= '{status: STATUS_OK, start_address: '0};
        end
      end
      ST_WRITE: begin
        wr_idx <= AW'(wr_idx + 1'b1);
        left   <= left - AmountW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit contiguous allocator over a pool of POOL_UNITS units.
// ----------------------------------------------------------------------------
// Each item is a request (func 0, amount = units wanted) or a release
// (func 1, amount = start unit). Every item yields one result item with a
// status and, for a granted request, the start unit. After reset the block
// runs a clearing pass over every unit of both memories before it takes
// its first item. One item is handled at a time. A request scans the
// used-map RAM one unit per cycle from unit 0 until a run fits or the
// pool ends, then marks the run used. A release reads the length RAM once
// and frees one unit per cycle; one that names no block start gets an
// error. Bad sizes and out-of-range addresses are answered without a scan
// or a freeing pass. The result sits in an output register, so the next
// item can be taken while it waits.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int POOL_UNITS = PoolUnitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [AmountW-1:0] amount,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [StartW-1:0]  start_address
);

  localparam int AW = $clog2(POOL_UNITS);

  logic               res_valid, res_ready;
  ffba_res_t          res;
  logic               used_we, used_wdata, used_rdata;
  logic [AW-1:0]      used_waddr, used_raddr;
  logic               blen_we;
  logic [AW-1:0]      blen_waddr, blen_raddr;
  logic [AmountW-1:0] blen_wdata, blen_rdata;

  ffba_ctrl #(
    .POOL_UNITS (POOL_UNITS),
    .AW         (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .amount     (amount),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .used_we    (used_we),
    .used_waddr (used_waddr),
    .used_wdata (used_wdata),
    .used_raddr (used_raddr),
    .used_rdata (used_rdata),
    .blen_we    (blen_we),
    .blen_waddr (blen_waddr),
    .blen_wdata (blen_wdata),
    .blen_raddr (blen_raddr),
    .blen_rdata (blen_rdata)
  );

  ffba_ram #(
    .DEPTH (POOL_UNITS),
    .WIDTH (1),
    .AW    (AW)
  ) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .raddr (used_raddr),
    .rdata (used_rdata)
  );

  ffba_ram #(
    .DEPTH (POOL_UNITS),
    .WIDTH (AmountW),
    .AW    (AW)
  ) u_blen_ram (
    .clk   (clk),
    .we    (blen_we),
    .waddr (blen_waddr),
    .wdata (blen_wdata),
    .raddr (blen_raddr),
    .rdata (blen_rdata)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status        <= res.status;
      start_address <= res.start_address;
    end
  end

`ifndef SYNTH
  a_load: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> out_valid)
    else $error("result handed off but output register not loaded");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new item taken while previous item in progress");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_stall)
    else $error("item taken while a result is pending");

  a_err_addr_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == STATUS_ERR) |-> (res.start_address == '0))
    else $error("error result carries a nonzero start address");
`endif

endmodule
